### design/assert_macros.svh
// Assertion helpers used by the core design file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// Same-cycle implication, checked on every rising edge out of reset.
`define E2D_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("assertion failed");
// Next-cycle implication.
`define E2D_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define E2D_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define E2D_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

### design/e2d_pkg.sv
`timescale 1ns / 1ps
package e2d_pkg;
	localparam int CORDIC_STAGES_DEF = 16;
	localparam int FRAC_BITS_DEF = 16;
	localparam int ATAN_LEN = 24;
	// Width of the Q30 CORDIC datapath, with headroom for sign and gain.
	localparam int CW = 34;
	localparam logic [24:0] DEG_TO_RAD_Q30 = 25'd18740330;
	localparam logic signed [CW-1:0] INV_GAIN_Q30 = 34'sd652032874;

	typedef struct packed {
		logic signed [CW-1:0] x;
		logic signed [CW-1:0] y;
		logic signed [CW-1:0] z;
		logic                 flip;
	} cord_t;

	// Arctangent of 2^-i in Q30, truncated.
	function automatic logic [31:0] atan_q30(input int i);
		logic [31:0] a;
		case (i)
			0: a = 32'h3243F6A8;  1: a = 32'h1DAC6705;
			2: a = 32'h0FADBAFC;  3: a = 32'h07F56EA6;
			4: a = 32'h03FEAB76;  5: a = 32'h01FFD55B;
			6: a = 32'h00FFFAAA;  7: a = 32'h007FFF55;
			8: a = 32'h003FFFEA;  9: a = 32'h001FFFFD;
			10: a = 32'h000FFFFF; 11: a = 32'h0007FFFF;
			12: a = 32'h0003FFFF; 13: a = 32'h0001FFFF;
			14: a = 32'h0000FFFF; 15: a = 32'h00007FFF;
			16: a = 32'h00003FFF; 17: a = 32'h00001FFF;
			18: a = 32'h00000FFF; 19: a = 32'h000007FF;
			20: a = 32'h000003FF; 21: a = 32'h000001FF;
			22: a = 32'h000000FF; 23: a = 32'h0000007F;
			default: a = 32'h0;
		endcase
		return a;
	endfunction
endpackage

### design/euler_to_direction_vectors_core.sv
`timescale 1ns / 1ps
// Channel  Direction  Handshake              Payload
// in       into core  in_valid / in_stall    pitch_deg, yaw_deg, roll_deg
// out      from core  out_valid / out_stall  forward_*, right_*, up_* (Q1.16)
//
// One request enters per cycle while the pipeline is not held by out_stall;
// the CORDIC cell chain has one cell per stage.
// Reset clears only the valid bits of the pipeline.
// When the output register holds a result and out_stall is high, the whole
// pipeline holds and in_stall is raised in the same cycle.
`include "assert_macros.svh"
module euler_to_direction_vectors_core import e2d_pkg::*; #(
	parameter int CORDIC_STAGES = CORDIC_STAGES_DEF,
	parameter int FRAC_BITS     = FRAC_BITS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic signed [FRAC_BITS+9:0] pitch_deg,
	input  logic signed [FRAC_BITS+9:0] yaw_deg,
	input  logic signed [FRAC_BITS+9:0] roll_deg,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic signed [FRAC_BITS+1:0] forward_x,
	output logic signed [FRAC_BITS+1:0] forward_y,
	output logic signed [FRAC_BITS+1:0] forward_z,
	output logic signed [FRAC_BITS+1:0] right_x,
	output logic signed [FRAC_BITS+1:0] right_y,
	output logic signed [FRAC_BITS+1:0] right_z,
	output logic signed [FRAC_BITS+1:0] up_x,
	output logic signed [FRAC_BITS+1:0] up_y,
	output logic signed [FRAC_BITS+1:0] up_z
);
	// Two front-end stages, the cell chain, and three combine stages.
	localparam int LAT = CORDIC_STAGES + 5;

	logic                        adv;
	logic [LAT-1:0]              vld_q;
	logic signed [FRAC_BITS+9:0] ang [3];
	cord_t                       chain [3][CORDIC_STAGES+1];
	logic signed [FRAC_BITS+1:0] res [9];

	// The pipeline moves as a whole unless a finished result is being held.
	assign adv      = !(out_valid && out_stall);
	assign in_stall = !adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (adv) begin
			vld_q <= {vld_q[LAT-2:0], in_valid};
		end
	end
	assign out_valid = vld_q[LAT-1];

	assign ang[0] = pitch_deg;
	assign ang[1] = yaw_deg;
	assign ang[2] = roll_deg;

	// Each angle gets its own front end and its own row of CORDIC cells.
	for (genvar a = 0; a < 3; a++) begin : g_ang
		e2d_angle #(.FRAC_BITS(FRAC_BITS)) u_angle (
			.clk(clk), .adv(adv), .angle(ang[a]), .start_s2(chain[a][0])
		);
		for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cell
			e2d_cordic_cell #(.IDX(i)) u_cell (
				.clk(clk), .adv(adv), .d(chain[a][i]), .q(chain[a][i+1])
			);
		end
	end

	// Products of the sines and cosines; the last stage is the output register.
	e2d_combine #(.FRAC_BITS(FRAC_BITS)) u_combine (
		.clk(clk), .adv(adv),
		.pc(chain[0][CORDIC_STAGES]),
		.yc(chain[1][CORDIC_STAGES]),
		.rc(chain[2][CORDIC_STAGES]),
		.res_s3(res)
	);

	assign forward_x = res[0];
	assign forward_y = res[1];
	assign forward_z = res[2];
	assign right_x   = res[3];
	assign right_y   = res[4];
	assign right_z   = res[5];
	assign up_x      = res[6];
	assign up_y      = res[7];
	assign up_z      = res[8];

	// The input is held back only while a finished result waits downstream.
	`E2D_ASSERT_IMP(a_stall_src, clk, arst_n, in_stall, out_valid && out_stall)
	// A held result keeps every request in flight where it is.
	`E2D_ASSERT_NXT(a_hold, clk, arst_n, out_valid && out_stall, $stable(vld_q))
	// Saturation keeps every component within plus or minus one; checked here on up_z.
	`E2D_ASSERT_IMP(a_sat, clk, arst_n, out_valid, (up_z <= (1 <<< FRAC_BITS)) && (up_z >= -(1 <<< FRAC_BITS)))
endmodule

### design/e2d_angle.sv
`timescale 1ns / 1ps
module e2d_angle import e2d_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic                        clk,
	input  logic                        adv,
	input  logic signed [FRAC_BITS+9:0] angle,
	output cord_t                       start_s2
);
	localparam int AW = FRAC_BITS + 12;
	localparam int MW = FRAC_BITS + 7;
	localparam int PW = MW + 25;
	localparam logic signed [AW-1:0] FULL    = AW'(360) << FRAC_BITS;
	localparam logic signed [AW-1:0] HALF    = AW'(180) << FRAC_BITS;
	localparam logic signed [AW-1:0] QUARTER = AW'(90) << FRAC_BITS;
	localparam logic [PW-1:0] RND = PW'(1) << (FRAC_BITS - 1);

	logic signed [AW-1:0] a_ext, t, r, f;
	logic                 flip;
	logic [AW-1:0]        mag;
	logic [MW-1:0]        m_s1;
	logic                 neg_s1, flip_s1;
	logic [PW-1:0]        prod;
	logic [PW-1:0]        zmag;
	logic signed [CW-1:0] z;

	// Wrap into (-180, 180] and fold into [-90, 90].
	always_comb begin
		a_ext = AW'(angle);
		if (a_ext < -FULL) begin
			t = a_ext + FULL + FULL;
		end else if (a_ext < 0) begin
			t = a_ext + FULL;
		end else if (a_ext >= FULL) begin
			t = a_ext - FULL;
		end else begin
			t = a_ext;
		end
		r = (t > HALF) ? t - FULL : t;
		flip = 1'b0;
		f = r;
		if (r > QUARTER) begin
			f = r - HALF;
			flip = 1'b1;
		end else if (r < -QUARTER) begin
			f = r + HALF;
			flip = 1'b1;
		end
		mag = f[AW-1] ? AW'(-f) : AW'(f);
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			m_s1    <= mag[MW-1:0];
			neg_s1  <= f[AW-1];
			flip_s1 <= flip;
		end
	end

	always_comb begin
		prod = PW'(m_s1) * PW'(DEG_TO_RAD_Q30);
		zmag = (prod + RND) >> FRAC_BITS;
		z = neg_s1 ? -CW'(zmag) : CW'(zmag);
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			start_s2.x    <= INV_GAIN_Q30;
			start_s2.y    <= '0;
			start_s2.z    <= z;
			start_s2.flip <= flip_s1;
		end
	end
endmodule

### design/e2d_cordic_cell.sv
`timescale 1ns / 1ps
module e2d_cordic_cell import e2d_pkg::*; #(
	parameter int IDX = 0
) (
	input  logic  clk,
	input  logic  adv,
	input  cord_t d,
	output cord_t q
);
	localparam logic signed [CW-1:0] ATAN = CW'(atan_q30(IDX));

	logic signed [CW-1:0] dx, dy;

	// Arithmetic shifts round toward minus infinity.
	assign dx = d.y >>> IDX;
	assign dy = d.x >>> IDX;

	always_ff @(posedge clk) begin
		if (adv) begin
			q.flip <= d.flip;
			if (!d.z[CW-1]) begin
				q.x <= d.x - dx;
				q.y <= d.y + dy;
				q.z <= d.z - ATAN;
			end else begin
				q.x <= d.x + dx;
				q.y <= d.y - dy;
				q.z <= d.z + ATAN;
			end
		end
	end
endmodule

### design/e2d_combine.sv
`timescale 1ns / 1ps
module e2d_combine import e2d_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic                        clk,
	input  logic                        adv,
	input  cord_t                       pc,
	input  cord_t                       yc,
	input  cord_t                       rc,
	output logic signed [FRAC_BITS+1:0] res_s3 [9]
);
	localparam int PW = 2 * CW;
	localparam int SW = PW + 1;
	localparam int OW = FRAC_BITS + 2;
	localparam logic signed [PW-1:0] RND30 = PW'(1) << 29;
	localparam logic signed [SW-1:0] RNDF  = SW'(1) << (59 - FRAC_BITS);
	localparam logic signed [SW-1:0] LIM   = SW'(1) << FRAC_BITS;

	logic signed [CW-1:0] sp, cp, sy, cy, sr, cr;
	logic signed [PW-1:0] srsp_p, crsp_p;
	logic signed [CW-1:0] sp_s1, cp_s1, sy_s1, cy_s1, sr_s1, cr_s1, srsp_s1, crsp_s1;
	logic signed [SW-1:0] sum [9];
	logic signed [SW-1:0] sum_s2 [9];

	function automatic logic signed [OW-1:0] finish(input logic signed [SW-1:0] v);
		logic signed [SW-1:0] t;
		t = (v + RNDF) >>> (60 - FRAC_BITS);
		if (t > LIM) begin
			t = LIM;
		end else if (t < -LIM) begin
			t = -LIM;
		end
		return t[OW-1:0];
	endfunction

	// The fold is undone here: both sine and cosine change sign.
	always_comb begin
		sp = pc.flip ? -pc.y : pc.y;
		cp = pc.flip ? -pc.x : pc.x;
		sy = yc.flip ? -yc.y : yc.y;
		cy = yc.flip ? -yc.x : yc.x;
		sr = rc.flip ? -rc.y : rc.y;
		cr = rc.flip ? -rc.x : rc.x;
		srsp_p = (PW'(sr) * PW'(sp) + RND30) >>> 30;
		crsp_p = (PW'(cr) * PW'(sp) + RND30) >>> 30;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			sp_s1 <= sp; cp_s1 <= cp;
			sy_s1 <= sy; cy_s1 <= cy;
			sr_s1 <= sr; cr_s1 <= cr;
			srsp_s1 <= srsp_p[CW-1:0];
			crsp_s1 <= crsp_p[CW-1:0];
		end
	end

	always_comb begin
		sum[0] = SW'(cp_s1) * SW'(cy_s1);
		sum[1] = SW'(cp_s1) * SW'(sy_s1);
		sum[2] = -(SW'(sp_s1) <<< 30);
		sum[3] = -(SW'(srsp_s1) * SW'(cy_s1)) + SW'(cr_s1) * SW'(sy_s1);
		sum[4] = -(SW'(srsp_s1) * SW'(sy_s1)) - SW'(cr_s1) * SW'(cy_s1);
		sum[5] = -(SW'(sr_s1) * SW'(cp_s1));
		sum[6] = SW'(crsp_s1) * SW'(cy_s1) + SW'(sr_s1) * SW'(sy_s1);
		sum[7] = SW'(crsp_s1) * SW'(sy_s1) - SW'(sr_s1) * SW'(cy_s1);
		sum[8] = SW'(cr_s1) * SW'(cp_s1);
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int k = 0; k < 9; k++) begin
				sum_s2[k] <= sum[k];
				res_s3[k] <= finish(sum_s2[k]);
			end
		end
	end
endmodule

### tb/tb_euler_to_direction_vectors_core.sv
`timescale 1ns / 1ps
module tb_euler_to_direction_vectors_core;
	import e2d_pkg::*;

	localparam int FB = FRAC_BITS_DEF;
	localparam int NST = CORDIC_STAGES_DEF;
	localparam int IW = FB + 10;
	localparam int OW = FB + 2;
	localparam int LATENCY = NST + 5;
	localparam int N_RANDOM = 1630;
	localparam longint CYCLE_LIMIT = 200000;
	localparam longint DEG = longint'(1) << FB;

	typedef struct packed {
		logic signed [OW-1:0] fx, fy, fz, rx, ry, rz, ux, uy, uz;
	} basis_t;

	// Scoreboard: computes the expected basis for each accepted angle triple
	// and compares results from the block in order.
	class basis_scoreboard;
		basis_t pending[$];
		int errors;
		int checked;

		function longint floor_shift(longint v, int s);
			return v >>> s;
		endfunction

		function void angle_sin_cos(logic [IW-1:0] raw, output longint s, output longint c);
			longint full, r, m, z, x, y, dx, dy;
			bit flip;
			full = 360 * DEG;
			flip = 0;
			r = longint'($signed(raw)) % full;
			if (r < 0) r += full;
			if (r > 180 * DEG) r -= full;
			if (r > 90 * DEG) begin
				r -= 180 * DEG;
				flip = 1;
			end else if (r < -90 * DEG) begin
				r += 180 * DEG;
				flip = 1;
			end
			m = (r < 0) ? -r : r;
			z = (m * 18740330 + (longint'(1) << (FB - 1))) >>> FB;
			if (r < 0) z = -z;
			x = 652032874;
			y = 0;
			for (int i = 0; i < NST && i < ATAN_LEN; i++) begin
				dx = floor_shift(y, i);
				dy = floor_shift(x, i);
				if (z >= 0) begin
					x -= dx; y += dy; z -= longint'(atan_q30(i));
				end else begin
					x += dx; y -= dy; z += longint'(atan_q30(i));
				end
			end
			if (flip) begin
				x = -x; y = -y;
			end
			s = y;
			c = x;
		endfunction

		function logic signed [OW-1:0] to_q16(longint v);
			longint r, lim;
			lim = DEG;
			r = floor_shift(v + (longint'(1) << (59 - FB)), 60 - FB);
			if (r > lim) r = lim;
			if (r < -lim) r = -lim;
			return r[OW-1:0];
		endfunction

		function void note_request(logic [IW-1:0] p, logic [IW-1:0] yw, logic [IW-1:0] rl);
			longint sp, cp, sy, cy, sr, cr, srsp, crsp;
			basis_t b;
			angle_sin_cos(p, sp, cp);
			angle_sin_cos(yw, sy, cy);
			angle_sin_cos(rl, sr, cr);
			srsp = floor_shift(sr * sp + (longint'(1) << 29), 30);
			crsp = floor_shift(cr * sp + (longint'(1) << 29), 30);
			b.fx = to_q16(cp * cy);
			b.fy = to_q16(cp * sy);
			b.fz = to_q16(-sp * (longint'(1) << 30));
			b.rx = to_q16(-srsp * cy + cr * sy);
			b.ry = to_q16(-srsp * sy - cr * cy);
			b.rz = to_q16(-sr * cp);
			b.ux = to_q16(crsp * cy + sr * sy);
			b.uy = to_q16(crsp * sy - sr * cy);
			b.uz = to_q16(cr * cp);
			pending.push_back(b);
		endfunction

		function void compare(string name, logic signed [OW-1:0] e, logic signed [OW-1:0] a);
			if (e !== a) begin
				errors++;
				$display("%0t: %s mismatch, expected %0d, got %0d", $time, name, e, a);
			end
		endfunction

		function void check_result(basis_t got);
			basis_t e;
			checked++;
			if (pending.size() == 0) begin
				errors++;
				$display("%0t: result with no request outstanding", $time);
				return;
			end
			e = pending.pop_front();
			compare("forward_x", e.fx, got.fx);
			compare("forward_y", e.fy, got.fy);
			compare("forward_z", e.fz, got.fz);
			compare("right_x", e.rx, got.rx);
			compare("right_y", e.ry, got.ry);
			compare("right_z", e.rz, got.rz);
			compare("up_x", e.ux, got.ux);
			compare("up_y", e.uy, got.uy);
			compare("up_z", e.uz, got.uz);
		endfunction
	endclass

	logic clk = 0;
	logic arst_n = 1;
	logic in_valid = 0;
	logic in_stall;
	logic signed [IW-1:0] pitch_deg = '0, yaw_deg = '0, roll_deg = '0;
	logic out_valid;
	logic out_stall = 1;
	logic signed [OW-1:0] forward_x, forward_y, forward_z;
	logic signed [OW-1:0] right_x, right_y, right_z;
	logic signed [OW-1:0] up_x, up_y, up_z;

	basis_scoreboard board;
	// While set, the receiver holds off so the pipeline fills and backs up.
	bit hold_off = 0;
	longint cycles = 0;

	always begin
		#2 clk = 1;
		#2 clk = 0;
	end

	euler_to_direction_vectors_core dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.pitch_deg(pitch_deg), .yaw_deg(yaw_deg), .roll_deg(roll_deg),
		.out_valid(out_valid), .out_stall(out_stall),
		.forward_x(forward_x), .forward_y(forward_y), .forward_z(forward_z),
		.right_x(right_x), .right_y(right_y), .right_z(right_z),
		.up_x(up_x), .up_y(up_y), .up_z(up_z)
	);

	// Offers one request and waits for the block to take it. The expected
	// basis is recorded at the accepting edge.
	task automatic send_request(logic [IW-1:0] p, logic [IW-1:0] yw, logic [IW-1:0] rl);
		int gap;
		gap = $urandom_range(0, 15);
		if ($urandom_range(0, 3) == 0) gap = 0;
		repeat (gap) begin
			in_valid <= 0;
			@(negedge clk);
		end
		in_valid <= 1;
		pitch_deg <= p;
		yaw_deg <= yw;
		roll_deg <= rl;
		do @(posedge clk); while (in_stall);
		board.note_request(p, yw, rl);
		@(negedge clk);
	endtask

	// Angles: most within one turn, some anywhere in the 26-bit range.
	function automatic logic [IW-1:0] pick_angle();
		case ($urandom_range(0, 9))
			0, 1: return IW'($urandom());
			2: return IW'($signed($urandom_range(0, 8)) * 45 * DEG
				- 180 * DEG + $signed($urandom_range(0, 2)) - 1);
			default: return IW'(longint'($urandom_range(0, 32'(720 * DEG))) - 360 * DEG);
		endcase
	endfunction

	// Receiver: draws a stall length per result, or follows the hold-off.
	initial begin
		int wait_cycles;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_off) begin
				out_stall <= 1;
			end else begin
				wait_cycles = $urandom_range(0, 15);
				if ($urandom_range(0, 3) == 0) wait_cycles = 0;
				if (wait_cycles > 0) begin
					out_stall <= 1;
					repeat (wait_cycles - 1) @(negedge clk);
					@(negedge clk);
				end
				out_stall <= 0;
				do @(posedge clk); while (!out_valid && !hold_off);
			end
		end
	end

	always @(posedge clk) begin
		basis_t got;
		if (arst_n && out_valid && !out_stall) begin
			got = '{forward_x, forward_y, forward_z, right_x, right_y, right_z,
				up_x, up_y, up_z};
			board.check_result(got);
		end
	end

	// Long hold-off on the output while the sender keeps offering requests.
	initial begin
		@(posedge arst_n);
		repeat (300) @(posedge clk);
		@(negedge clk);
		hold_off = 1;
		repeat (200) @(posedge clk);
		@(negedge clk);
		hold_off = 0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles", cycles);
			$display("Some tests failed");
			$finish;
		end
	end

	initial begin
		longint edge_vals[$];
		board = new();
		#1 arst_n = 0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1;
		@(negedge clk);

		// Directed part: range ends, quarter turns (exactly 90 degrees is not
		// folded), half turns, full turns and values past a full turn.
		edge_vals = '{0, 90 * DEG, -90 * DEG, 180 * DEG, -180 * DEG, 360 * DEG,
			-360 * DEG, 90 * DEG + 1, -90 * DEG - 1, 270 * DEG, 1, -1,
			{1'b0, {(IW-1){1'b1}}}, {1'b1, {(IW-1){1'b0}}}, 45 * DEG,
			540 * DEG + 5, 180 * DEG + 1, -180 * DEG + 1};
		foreach (edge_vals[i])
			send_request(IW'(edge_vals[i]), IW'(edge_vals[(i + 3) % edge_vals.size()]),
				IW'(edge_vals[(i + 7) % edge_vals.size()]));
		send_request(IW'(30 * DEG), IW'(60 * DEG), IW'(-45 * DEG));
		send_request(IW'(-90 * DEG), IW'(90 * DEG), IW'(180 * DEG));

		for (int n = 0; n < N_RANDOM; n++)
			send_request(pick_angle(), pick_angle(), pick_angle());
		in_valid <= 0;

		while (board.pending.size() != 0) @(posedge clk);
		repeat (LATENCY + 10) @(posedge clk);

		$display("Checked %0d direction-vector results, including wrapped angles,",
			board.checked);
		$display("quarter and half turns, range ends, and a long output hold-off.");
		if (board.errors == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end
endmodule
